FILE: rtl/dnmt_pkg.sv
// shared constants, codes and helpers for the domain name match table
// no dependencies; used by every other file of the block but dnmt_if
`default_nettype none
package dnmt_pkg;

  localparam int ENTRIES  = 64;
  localparam int NAME_LEN = 256;
  localparam int POS_W    = $clog2(NAME_LEN);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_MISS    = 3'd0,
    ST_HIT     = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_ADDED   = 3'd3,
    ST_UPDATED = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_HIT,
    S_RES
  } state_t;

  // ascii upper case to lower case, other bytes as they are
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dnmt_if.sv
// request and response channel interfaces
// does not depend on dnmt_pkg; the fields have plain widths
`default_nettype none
interface dnmt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  name_char;
  logic        last_char;
  logic [31:0] new_address;
  modport source(output valid, opcode, name_char, last_char, new_address, input ready);
  modport sink(input valid, opcode, name_char, last_char, new_address, output ready);
endinterface

interface dnmt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_address;
  logic [6:0]  entry_count;
  modport source(output valid, status, found_address, entry_count, input ready);
  modport sink(input valid, status, found_address, entry_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/dnmt_name_mem.sv
// name character memory: one row per character position, one byte lane per entry
// depends on dnmt_pkg for ENTRIES, NAME_LEN, POS_W and IDX_W
`default_nettype none
module dnmt_name_mem (
  input  wire logic                                clk,
  input  wire logic                                rd_en,
  input  wire logic [dnmt_pkg::POS_W-1:0]          rd_row,
  output      logic [dnmt_pkg::ENTRIES-1:0][7:0]   rd_data,
  input  wire logic                                wr_en,
  input  wire logic [dnmt_pkg::POS_W-1:0]          wr_row,
  input  wire logic [dnmt_pkg::IDX_W-1:0]          wr_lane,
  input  wire logic [7:0]                          wr_byte
);
  logic [dnmt_pkg::ENTRIES-1:0][7:0] mem [dnmt_pkg::NAME_LEN];

  // lane write, registered row read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_lane] <= wr_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/dnmt_addr_mem.sv
// per-entry address memory, one write and one registered read port
// depends on dnmt_pkg for ENTRIES and IDX_W
`default_nettype none
module dnmt_addr_mem (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [dnmt_pkg::IDX_W-1:0] rd_idx,
  output      logic [31:0]                rd_data,
  input  wire logic                       wr_en,
  input  wire logic [dnmt_pkg::IDX_W-1:0] wr_idx,
  input  wire logic [31:0]                wr_data
);
  logic [31:0] mem [dnmt_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/domain_name_match_table.sv
// top level of the domain name match table: sequencer, match lanes, result register
// depends on dnmt_pkg, dnmt_if, dnmt_name_mem, dnmt_addr_mem
//
//   channel | dir | carries
//   req     | in  | opcode, name_char, last_char, new_address
//   rsp     | out | status, found_address, entry_count
//
// a character's row of the name memory is read when it is accepted; the compare
// state compares all entries in parallel and stores the byte. a final character
// then passes the hit state (priority select of the hit, address memory read) and
// the result state. clear and opcode three stay in idle. reset is synchronous and needs no sweep.
// a pending response stalls only a final character; others proceed.
`default_nettype none
module domain_name_match_table (
  input wire logic  clk,
  input wire logic  rst,
  dnmt_req_if.sink  req,
  dnmt_rsp_if.source rsp
);
  localparam int E = dnmt_pkg::ENTRIES;
  localparam int PW = dnmt_pkg::POS_W;
  localparam int CW = dnmt_pkg::CNT_W;
  localparam int IW = dnmt_pkg::IDX_W;
  localparam logic [PW-1:0] POS_MAX = PW'(dnmt_pkg::NAME_LEN - 1);
  localparam logic [CW-1:0] FULL = CW'(E);

  dnmt_pkg::state_t state, state_next;

  logic [PW-1:0]  pos;
  logic           too_long;
  logic [CW-1:0]  used;
  logic           stopped;
  logic [E-1:0]   match;
  logic [PW-1:0]  lens [E];

  logic [1:0]     op_r;
  logic [7:0]     char_r;
  logic           last_r;
  logic [31:0]    addr_r;
  logic           skip_r;
  logic           hit_any;
  logic [IW-1:0]  hit_idx;

  logic           out_valid;
  logic [2:0]     out_status;
  logic [31:0]    out_found;
  logic [CW-1:0]  out_count;

  logic [E-1:0][7:0] row;
  logic [31:0]    addr_rd;

  logic           accept;
  logic           name_rd;
  logic           char_wr;
  logic           hit_any_c;
  logic [IW-1:0]  hit_idx_c;
  logic [E-1:0]   match_next;
  logic           out_free;
  logic           addr_wr;
  logic [IW-1:0]  addr_wr_idx;
  logic [2:0]     res_status;
  logic [31:0]    res_found;
  logic [CW-1:0]  used_next;
  logic           stop_next;
  logic           add_entry;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  dnmt_name_mem u_name (
    .clk     (clk),
    .rd_en   (name_rd),
    .rd_row  (pos),
    .rd_data (row),
    .wr_en   (char_wr),
    .wr_row  (pos),
    .wr_lane (used[IW-1:0]),
    .wr_byte (char_r)
  );

  dnmt_addr_mem u_addr (
    .clk     (clk),
    .rd_en   (state == dnmt_pkg::S_HIT),
    .rd_idx  (hit_idx_c),
    .rd_data (addr_rd),
    .wr_en   (addr_wr),
    .wr_idx  (addr_wr_idx),
    .wr_data (addr_r)
  );

  // match lanes, one per entry
  always_comb begin
    for (int i = 0; i < E; i++) begin
      match_next[i] = match[i] && (pos < lens[i]) &&
                      (dnmt_pkg::fold_case(row[i]) == dnmt_pkg::fold_case(char_r));
    end
  end

  // lowest entry whose name matched over its full length
  always_comb begin
    hit_any_c = 1'b0;
    hit_idx_c = '0;
    for (int i = E - 1; i >= 0; i--) begin
      if (match[i] && lens[i] == pos && CW'(i) < used && !too_long) begin
        hit_any_c = 1'b1;
        hit_idx_c = IW'(i);
      end
    end
  end

  // result of a finished name
  always_comb begin
    res_status  = dnmt_pkg::ST_MISS;
    res_found   = '0;
    used_next   = used;
    stop_next   = stopped;
    addr_wr     = 1'b0;
    addr_wr_idx = hit_idx;
    add_entry   = 1'b0;
    if (op_r == dnmt_pkg::OP_LOOKUP) begin
      if (hit_any) begin
        res_found  = addr_rd;
        res_status = (addr_rd == '0) ? dnmt_pkg::ST_BLOCKED : dnmt_pkg::ST_HIT;
      end
    end else if (stopped || too_long) begin
      res_status = dnmt_pkg::ST_IGNORED;
    end else if (hit_any) begin
      res_status = dnmt_pkg::ST_UPDATED;
      addr_wr    = 1'b1;
    end else if (used >= FULL) begin
      stop_next  = 1'b1;
      res_status = dnmt_pkg::ST_IGNORED;
    end else begin
      res_status  = dnmt_pkg::ST_ADDED;
      addr_wr     = 1'b1;
      addr_wr_idx = used[IW-1:0];
      add_entry   = 1'b1;
      used_next   = used + 1'b1;
    end
    if (!(state == dnmt_pkg::S_RES && out_free)) begin
      addr_wr = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dnmt_pkg::S_IDLE: begin
        if (accept && (req.opcode == dnmt_pkg::OP_INSERT ||
                       req.opcode == dnmt_pkg::OP_LOOKUP)) begin
          state_next = dnmt_pkg::S_CMP;
        end
      end
      dnmt_pkg::S_CMP: state_next = last_r ? dnmt_pkg::S_HIT : dnmt_pkg::S_IDLE;
      dnmt_pkg::S_HIT: state_next = dnmt_pkg::S_RES;
      dnmt_pkg::S_RES: if (out_free) state_next = dnmt_pkg::S_IDLE;
      default: state_next = dnmt_pkg::S_IDLE;
    endcase
  end

  // handshake and memory controls
  always_comb begin
    req.ready = (state == dnmt_pkg::S_IDLE);
    name_rd   = accept;
    char_wr   = (state == dnmt_pkg::S_CMP) && !skip_r && (used < FULL);
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_address = out_found;
  assign rsp.entry_count   = 7'(out_count);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dnmt_pkg::S_IDLE;
      pos       <= '0;
      too_long  <= 1'b0;
      used      <= '0;
      stopped   <= 1'b0;
      match     <= '1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // response valid: set on a new result, dropped once taken
      if (state == dnmt_pkg::S_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        dnmt_pkg::S_IDLE: begin
          if (accept && req.opcode == dnmt_pkg::OP_CLEAR) begin
            used     <= '0;
            stopped  <= 1'b0;
            match    <= '1;
            pos      <= '0;
            too_long <= 1'b0;
          end
        end
        dnmt_pkg::S_CMP: begin
          if (skip_r) begin
            too_long <= 1'b1;
          end else begin
            match <= match_next;
            pos   <= pos + 1'b1;
          end
        end
        dnmt_pkg::S_RES: begin
          if (out_free) begin
            used      <= used_next;
            stopped   <= stop_next;
            match     <= '1;
            pos       <= '0;
            too_long  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= req.opcode;
      char_r <= req.name_char;
      last_r <= req.last_char;
      addr_r <= req.new_address;
      skip_r <= too_long || (pos >= POS_MAX);
    end
    if (state == dnmt_pkg::S_HIT) begin
      hit_any <= hit_any_c;
      hit_idx <= hit_idx_c;
    end
    if (state == dnmt_pkg::S_RES && out_free) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_count  <= used_next;
      if (add_entry) begin
        lens[used[IW-1:0]] <= pos;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/dnmt_checker.sv
// port-level checks of the domain name match table, bound to the top level
// depends on dnmt_pkg and the channel interfaces
`default_nettype none
module dnmt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  rsp_status,
  input wire logic [31:0] rsp_found,
  input wire logic [6:0]  rsp_count
);
  // a stalled response holds its status and address
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found))
    else $error("response changed while stalled");

  // count never exceeds the table size
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_count) <= 32'(dnmt_pkg::ENTRIES) || dnmt_pkg::ENTRIES > 127)
    else $error("entry count beyond table size");

  // a hit carries a nonzero address
  a_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == dnmt_pkg::ST_HIT |-> rsp_found != '0)
    else $error("hit with zero address");

  // anything other than a hit carries a zero address
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != dnmt_pkg::ST_HIT |-> rsp_found == '0)
    else $error("address on a non-hit response");
endmodule

bind domain_name_match_table dnmt_checker u_dnmt_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_found  (rsp.found_address),
  .rsp_count  (rsp.entry_count)
);
`default_nettype wire

FILE: sim/dnmt_test_if.sv
// note: the block's interfaces are compiled from rtl/dnmt_if.sv; this file only
// holds the test's transaction types, shared by the test top
// depends on dnmt_pkg
`timescale 1ns / 1ps
package dnmt_test_pkg;
  import dnmt_pkg::*;

  typedef struct packed {
    opcode_t     op;
    logic [7:0]  ch;
    logic        last;
    logic [31:0] addr;
  } name_txn_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found;
    logic [6:0]  count;
  } match_txn_t;
endpackage

FILE: sim/domain_name_match_table_test.sv
// testbench for domain_name_match_table: directed and random name streams,
// each result checked against a behavioral table predictor
// depends on dnmt_pkg, dnmt_if, dnmt_test_pkg and the block's rtl
`timescale 1ns / 1ps
module domain_name_match_table_test;
  import dnmt_pkg::*;
  import dnmt_test_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dnmt_req_if req ();
  dnmt_rsp_if rsp ();

  domain_name_match_table i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the table
  logic [7:0]  tbl_chars [ENTRIES][NAME_LEN];
  int          tbl_len [ENTRIES];
  logic [31:0] tbl_addr [ENTRIES];
  int          tbl_used;
  bit          tbl_stopped;
  bit          cand [ENTRIES];
  int          cur_pos;
  bit          cur_long;

  match_txn_t expected_q[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;
  int  burst_left = 0;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void restart_name();
    for (int i = 0; i < ENTRIES; i++) cand[i] = 1'b1;
    cur_pos = 0;
    cur_long = 1'b0;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void predict_table(input name_txn_t t);
    int p;
    int hit;
    match_txn_t r;
    hit = -1;
    if (t.op == OP_NONE) return;
    if (t.op == OP_CLEAR) begin
      tbl_used = 0;
      tbl_stopped = 1'b0;
      restart_name();
      return;
    end
    p = cur_pos;
    if (cur_long || p >= NAME_LEN - 1) begin
      cur_long = 1'b1;
    end else begin
      for (int i = 0; i < tbl_used; i++)
        if (!(p < tbl_len[i] && lower(tbl_chars[i][p]) == lower(t.ch))) cand[i] = 1'b0;
      if (tbl_used < ENTRIES) tbl_chars[tbl_used][p] = t.ch;
      cur_pos = p + 1;
    end
    if (!t.last) return;
    if (!cur_long)
      for (int i = 0; i < tbl_used; i++)
        if (hit < 0 && cand[i] && tbl_len[i] == p + 1) hit = i;
    r.found = '0;
    if (t.op == OP_LOOKUP) begin
      if (hit < 0) r.status = ST_MISS;
      else begin
        r.found = tbl_addr[hit];
        r.status = (r.found == 0) ? ST_BLOCKED : ST_HIT;
      end
    end else if (tbl_stopped || cur_long) r.status = ST_IGNORED;
    else if (hit >= 0) begin
      tbl_addr[hit] = t.addr;
      r.status = ST_UPDATED;
    end else if (tbl_used >= ENTRIES) begin
      tbl_stopped = 1'b1;
      r.status = ST_IGNORED;
    end else begin
      tbl_len[tbl_used] = p + 1;
      tbl_addr[tbl_used] = t.addr;
      tbl_used++;
      r.status = ST_ADDED;
    end
    restart_name();
    r.count = 7'(tbl_used);
    expected_q.push_back(r);
  endfunction

  // send one transaction, with bursty gaps
  task automatic send_item(input opcode_t op, input logic [7:0] ch, input bit last,
                           input logic [31:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.name_char <= ch;
    req.last_char <= last;
    req.new_address <= addr;
    do @(posedge clk); while (!req.ready);
    predict_table('{op, ch, last, addr});
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // stream a whole name; the last character carries op, the others a random lookup/insert opcode unless mix is off
  task automatic send_name(input opcode_t op, input string s, input logic [31:0] addr,
                           input bit mix = 1'b1);
    opcode_t o;
    for (int i = 0; i < s.len(); i++) begin
      o = (i == s.len() - 1 || !mix) ? op : ($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP);
      send_item(o, s[i], i == s.len() - 1, addr);
    end
  endtask

  function automatic string rand_name(input int n);
    string s;
    byte b;
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = byte'($urandom_range("a", "c"));
        1: b = byte'($urandom_range("A", "C"));
        2: b = byte'($urandom_range(0, 255));
        default: b = ".";
      endcase
      if (b == 0) b = 8'h80 | byte'($urandom_range(0, 127));
      s = {s, string'(b)};
    end
    return s;
  endfunction

  function automatic string flip_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 32;
    return r;
  endfunction

  // receiver stall pattern plus long hold-off
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !hold_off && (cycles % 7 < 5 || $urandom_range(0, 1));
  end

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      match_txn_t e;
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result status=%0d", rsp.status);
      end else begin
        e = expected_q.pop_front();
        if (rsp.status !== e.status || rsp.found_address !== e.found ||
            rsp.entry_count !== e.count) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d addr=%h cnt=%0d got st=%0d addr=%h cnt=%0d",
                     e.status, e.found, e.count, rsp.status, rsp.found_address,
                     rsp.entry_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_basics();
    send_item(OP_CLEAR, 8'h00, 1'b0, '0);
    send_name(OP_LOOKUP, "miss.example", '0);
    send_name(OP_INSERT, "Host.A", 32'h0A000001);
    send_name(OP_LOOKUP, "hOST.a", '0);
    send_name(OP_INSERT, "host.a", 32'hFFFFFFFF);
    send_name(OP_LOOKUP, "host.a", '0);
    send_name(OP_INSERT, "bad", 32'h0);
    send_name(OP_LOOKUP, "BAD", '0);
    send_name(OP_LOOKUP, "host", '0);
    send_name(OP_LOOKUP, "host.ab", '0);
    send_item(OP_INSERT, 8'h00, 1'b1, 32'h12345678);
    send_item(OP_LOOKUP, 8'h00, 1'b1, '0);
    send_item(OP_INSERT, 8'hFF, 1'b1, 32'h1);
    send_item(OP_NONE, 8'hA5, 1'b1, 32'hDEAD);
    send_item(OP_LOOKUP, "[", 1'b1, '0);
    send_item(OP_INSERT, "x", 1'b0, '0);
    send_item(OP_CLEAR, 8'h00, 1'b1, '0);
    send_name(OP_LOOKUP, "host.a", '0);
  endtask

  // names at and beyond the length limit
  task automatic test_long_names();
    string s;
    s = "";
    for (int i = 0; i < NAME_LEN - 1; i++) s = {s, "q"};
    send_name(OP_INSERT, s, 32'h55AA55AA, 1'b0);
    send_name(OP_LOOKUP, {s, "q"}, '0, 1'b0);
  endtask

  // fill the table while the receiver holds off, then hit the full case
  task automatic test_full_table();
    send_item(OP_CLEAR, 8'h00, 1'b0, '0);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < ENTRIES; i++)
      send_name(OP_INSERT, $sformatf("n%0d", i), $urandom, 1'b0);
    send_name(OP_INSERT, "overflow", 32'h1);
    send_name(OP_INSERT, "n3", 32'h2);
    send_name(OP_LOOKUP, "N63", '0);
    send_name(OP_LOOKUP, "overflow", '0);
  endtask

  task automatic test_random();
    string pool[$];
    string s;
    int k;
    send_item(OP_CLEAR, 8'h00, 1'b0, '0);
    while (items_sent < 820) begin
      k = $urandom_range(0, 99);
      if (k < 2) send_item(OP_CLEAR, 8'($urandom), 1'($urandom), $urandom);
      else if (k < 4) send_item(OP_NONE, 8'($urandom), 1'($urandom), $urandom);
      else if (k < 40 || pool.size() == 0) begin
        s = rand_name($urandom_range(1, 6));
        pool.push_back(s);
        send_name(OP_INSERT, s, $urandom_range(0, 3) == 0 ? 32'h0 : $urandom);
      end else if (k < 55) begin
        send_name(OP_INSERT, flip_case(pool[$urandom_range(0, pool.size() - 1)]), $urandom);
      end else begin
        s = flip_case(pool[$urandom_range(0, pool.size() - 1)]);
        if ($urandom_range(0, 4) == 0) s = s.substr(0, s.len() - 2 < 0 ? 0 : s.len() - 2);
        send_name(OP_LOOKUP, s, $urandom);
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_CLEAR;
    req.name_char = '0;
    req.last_char = 1'b0;
    req.new_address = '0;
    tbl_used = 0;
    tbl_stopped = 1'b0;
    restart_name();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basics();
    test_long_names();
    test_full_table();
    test_random();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d transactions, checked %0d results (fill, overflow, long names, case)",
             items_sent, results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
